[sv/rass_pkg.sv]
// ----------------------------------------------------------------------------
// rass_pkg
// Shared widths, operation codes and status codes of the sparse set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rass_pkg;

   localparam int ELEM_W       = 10;          // element and slot fields
   localparam int ELEM_SPAN    = 1 << ELEM_W; // distinct element values
   localparam int RND_W        = 16;          // random word
   localparam int COUNT_PORT_W = 11;          // member count on the port
   localparam int EPOCH_W      = 6;           // membership tag

   // tag 0 marks an absent element; live epochs run first..last
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   typedef enum logic [2:0] {
      FUNC_ADD      = 3'd0,
      FUNC_REMOVE   = 3'd1,
      FUNC_CONTAINS = 3'd2,
      FUNC_GET      = 3'd3,
      FUNC_PICK     = 3'd4,
      FUNC_CLEAR    = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

endpackage

`default_nettype wire

[sv/rass_ram.sv]
// ----------------------------------------------------------------------------
// rass_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rass_ram #(
   parameter  int DEPTH  = 1024,
   parameter  int WIDTH  = 10,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/rass_div.sv]
// ----------------------------------------------------------------------------
// rass_div
// Restoring remainder unit: random word mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rass_div #(
   parameter int DIV_W = 11
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rass_pkg::RND_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]           divisor,
   output      logic                       done,
   output      logic [DIV_W-1:0]           remainder
);

   localparam int NUM_W  = rass_pkg::RND_W;
   localparam int STEP_W = $clog2(NUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W:0]    shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, num_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = DIV_W'(shifted - {1'b0, dsr_ff});
         end else begin
            rem_in = shifted[DIV_W-1:0];
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[sv/random_access_sparse_set.sv]
// ----------------------------------------------------------------------------
// random_access_sparse_set
// Sparse set of small integers: add, remove, contains, get, random pick, clear.
// ----------------------------------------------------------------------------
// Usage:
//  One request beat on req_* gives exactly one response beat on rsp_*. A beat
//  moves when valid is high and stall is low. req_stall is high while the
//  block works on an item, so items are handled one at a time.
//  States from request to response register; the next request is taken after resp:
//    add, contains, get ............ look, eval, resp
//    remove ........................ look, eval, move, resp (second dependent
//                                       pass to move the last member into the freed slot)
//    random pick ................... div (16-step remainder unit), look, eval, resp
//    clear, empty pick, bad index .. resp
//  The response register decouples the sides: a new request is taken while a
//  response still waits under rsp_stall; a second response waits in the engine.
//  Membership is an epoch tag stored beside each element's slot. Clear bumps
//  the epoch; when the tag space wraps, and after reset, a clearing pass over
//  all DEPTH entries (1024 by default) sweeps the element memory while
//  req_stall stays high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module random_access_sparse_set #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [2:0]                        req_func,
   input  wire logic [rass_pkg::ELEM_W-1:0]       req_element,
   input  wire logic [rass_pkg::ELEM_W-1:0]       req_slot_index,
   input  wire logic [rass_pkg::RND_W-1:0]        req_random_value,
   // response channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic                              rsp_hit,
   output      logic [rass_pkg::ELEM_W-1:0]       rsp_value_out,
   output      logic [1:0]                        rsp_status,
   output      logic [rass_pkg::COUNT_PORT_W-1:0] rsp_member_count
);

   // At most ELEM_SPAN distinct elements exist, so storage stops there.
   localparam int DEPTH = (MAX_ELEMENTS < rass_pkg::ELEM_SPAN) ?
                          MAX_ELEMENTS : rass_pkg::ELEM_SPAN;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int TW    = rass_pkg::EPOCH_W;
   localparam int EW    = TW + AW;   // element memory word: {tag, slot}
   localparam int DW    = rass_pkg::ELEM_W;
   localparam int PW    = rass_pkg::COUNT_PORT_W;

   typedef enum logic [2:0] {
      ST_WIPE,   // clearing pass over the element memory
      ST_IDLE,   // take a request
      ST_LOOK,   // memory reads issued
      ST_EVAL,   // read data back, first writes
      ST_MOVE,   // remove: last member into the freed slot
      ST_DIV,    // random pick: wait for remainder
      ST_RESP    // hand result to the response register
   } state_type;

   state_type                      state_ff, state_in;
   rass_pkg::func_type             func_ff, func_in;
   logic [DW-1:0]                  elem_ff, elem_in;
   logic [AW-1:0]                  slot_ff, slot_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [TW-1:0]                  epoch_ff, epoch_in;
   logic [AW-1:0]                  wipe_ff, wipe_in;
   logic                           need_wipe_ff, need_wipe_in;
   logic                           hit_ff, hit_in;
   logic [DW-1:0]                  value_ff, value_in;
   rass_pkg::status_type           status_ff, status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [DW-1:0]                  rsp_value_ff, rsp_value_in;
   rass_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                  rsp_count_ff, rsp_count_in;

   // memory ports
   logic          e_wr_en, e_rd_en, d_wr_en, d_rd_en;
   logic [AW-1:0] e_wr_addr, e_rd_addr, d_wr_addr, d_rd_addr;
   logic [EW-1:0] e_wr_data, e_rd_data;
   logic [DW-1:0] d_wr_data, d_rd_data;

   logic          div_start, div_done;
   logic [CW-1:0] div_rem;

   logic          accept;
   logic          rsp_free;
   logic          elem_ok;
   logic          present;
   logic [TW-1:0] e_tag;
   logic [AW-1:0] e_slot;
   logic [TW-1:0] move_tag;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign elem_ok   = ({1'b0, req_element} < (DW + 1)'(DEPTH));
   assign e_tag     = e_rd_data[EW-1:AW];
   assign e_slot    = e_rd_data[AW-1:0];
   assign present   = (e_tag == epoch_ff);
   // removing the last member itself: its entry must stay absent
   assign move_tag  = (d_rd_data == elem_ff) ? rass_pkg::EPOCH_NONE : epoch_ff;
   assign div_start = accept && (rass_pkg::func_type'(req_func) == rass_pkg::FUNC_PICK) &&
                      (count_ff != '0);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      elem_in       = elem_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      epoch_in      = epoch_ff;
      wipe_in       = wipe_ff;
      need_wipe_in  = need_wipe_ff;
      hit_in        = hit_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      e_wr_en   = 1'b0;
      e_wr_addr = elem_ff[AW-1:0];
      e_wr_data = {rass_pkg::EPOCH_NONE, e_slot};
      e_rd_en   = 1'b0;
      e_rd_addr = elem_ff[AW-1:0];
      d_wr_en   = 1'b0;
      d_wr_addr = slot_ff;
      d_wr_data = d_rd_data;
      d_rd_en   = 1'b0;
      d_rd_addr = slot_ff;

      unique case (state_ff)
         ST_WIPE: begin
            e_wr_en   = 1'b1;
            e_wr_addr = wipe_ff;
            e_wr_data = '0;
            wipe_in   = wipe_ff + AW'(1);
            if (wipe_ff == AW'(DEPTH - 1)) begin
               wipe_in      = '0;
               need_wipe_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               func_in   = rass_pkg::func_type'(req_func);
               elem_in   = req_element;
               slot_in   = req_slot_index[AW-1:0];
               hit_in    = 1'b0;
               value_in  = '0;
               status_in = rass_pkg::STATUS_OK;
               state_in  = ST_RESP;
               case (rass_pkg::func_type'(req_func))
                  rass_pkg::FUNC_ADD, rass_pkg::FUNC_REMOVE, rass_pkg::FUNC_CONTAINS: begin
                     if (elem_ok) begin
                        state_in = ST_LOOK;
                     end
                  end
                  rass_pkg::FUNC_GET: begin
                     if (PW'(req_slot_index) < PW'(count_ff)) begin
                        state_in = ST_LOOK;
                     end else begin
                        status_in = rass_pkg::STATUS_RANGE;
                     end
                  end
                  rass_pkg::FUNC_PICK: begin
                     if (count_ff == '0) begin
                        status_in = rass_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = ST_DIV;
                     end
                  end
                  rass_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                     if (epoch_ff == rass_pkg::EPOCH_LAST) begin
                        epoch_in     = rass_pkg::EPOCH_FIRST;
                        need_wipe_in = 1'b1;
                     end else begin
                        epoch_in = epoch_ff + TW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_DIV: begin
            if (div_done) begin
               slot_in  = div_rem[AW-1:0];
               state_in = ST_LOOK;
            end
         end

         ST_LOOK: begin
            e_rd_en  = 1'b1;
            d_rd_en  = 1'b1;
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            state_in = ST_RESP;
            case (func_ff)
               rass_pkg::FUNC_ADD: begin
                  if (!present && (count_ff < CW'(DEPTH))) begin
                     e_wr_en   = 1'b1;
                     e_wr_data = {epoch_ff, count_ff[AW-1:0]};
                     d_wr_en   = 1'b1;
                     d_wr_addr = count_ff[AW-1:0];
                     d_wr_data = elem_ff;
                     count_in  = count_ff + CW'(1);
                     hit_in    = 1'b1;
                  end
               end
               rass_pkg::FUNC_REMOVE: begin
                  if (present) begin
                     // drop membership now, fetch the last member
                     e_wr_en   = 1'b1;
                     e_wr_data = {rass_pkg::EPOCH_NONE, e_slot};
                     count_in  = count_ff - CW'(1);
                     slot_in   = e_slot;
                     d_rd_en   = 1'b1;
                     d_rd_addr = AW'(count_ff - CW'(1));
                     hit_in    = 1'b1;
                     state_in  = ST_MOVE;
                  end
               end
               rass_pkg::FUNC_CONTAINS: begin
                  hit_in = present;
               end
               rass_pkg::FUNC_GET, rass_pkg::FUNC_PICK: begin
                  value_in = d_rd_data;
               end
               default: begin
               end
            endcase
         end

         ST_MOVE: begin
            d_wr_en   = 1'b1;
            d_wr_addr = slot_ff;
            d_wr_data = d_rd_data;
            e_wr_en   = 1'b1;
            e_wr_addr = d_rd_data[AW-1:0];
            e_wr_data = {move_tag, slot_ff};
            state_in  = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = hit_ff;
               rsp_value_in  = value_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               state_in      = need_wipe_ff ? ST_WIPE : ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         count_ff     <= '0;
         epoch_ff     <= rass_pkg::EPOCH_FIRST;
         wipe_ff      <= '0;
         need_wipe_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         epoch_ff     <= epoch_in;
         wipe_ff      <= wipe_in;
         need_wipe_ff <= need_wipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      elem_ff       <= elem_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // element -> {epoch tag, dense slot}
   rass_ram #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_en   (e_rd_en),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   // dense slot -> element
   rass_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DW)
   ) u_dense_ram (
      .clock   (clock),
      .wr_en   (d_wr_en),
      .wr_addr (d_wr_addr),
      .wr_data (d_wr_data),
      .rd_en   (d_rd_en),
      .rd_addr (d_rd_addr),
      .rd_data (d_rd_data)
   );

   rass_div #(
      .DIV_W (CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_random_value),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_value_out    = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_member_count = PW'(rsp_count_ff);

endmodule

`default_nettype wire

[tb/sv/random_access_sparse_set_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_access_sparse_set_check
// Watches both channels of the sparse set, predicts every response beat from
// its own copy of the set and compares the beats field by field.
// ----------------------------------------------------------------------------

module random_access_sparse_set_check (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic [2:0]                        req_func,
   input  wire logic [rass_pkg::ELEM_W-1:0]       req_element,
   input  wire logic [rass_pkg::ELEM_W-1:0]       req_slot_index,
   input  wire logic [rass_pkg::RND_W-1:0]        req_random_value,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic                              rsp_hit,
   input  wire logic [rass_pkg::ELEM_W-1:0]       rsp_value_out,
   input  wire logic [1:0]                        rsp_status,
   input  wire logic [rass_pkg::COUNT_PORT_W-1:0] rsp_member_count,
   output int unsigned                            fail_total,
   output int unsigned                            pending,
   output int unsigned                            answered
);

   localparam int ELEM_W       = rass_pkg::ELEM_W;
   localparam int RND_W        = rass_pkg::RND_W;
   localparam int COUNT_PORT_W = rass_pkg::COUNT_PORT_W;
   localparam int SET_SIZE     = rass_pkg::ELEM_SPAN;

   typedef struct {
      int unsigned              serial;
      logic [2:0]               op;
      logic                     hit;
      logic [ELEM_W-1:0]        value;
      rass_pkg::status_type     status;
      logic [COUNT_PORT_W-1:0]  count;
   } set_answer_type;

   // shadow copy of the set
   logic [SET_SIZE-1:0]       in_set;
   logic [ELEM_W-1:0]         dense_slots [SET_SIZE];
   logic [ELEM_W-1:0]         slot_of     [SET_SIZE];
   logic [COUNT_PORT_W-1:0]   members;

   set_answer_type awaited [$];
   int unsigned    errors   = 0;
   int unsigned    checks   = 0;
   int unsigned    accepted = 0;

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t ns  sparse set mismatch: %s", $time, what);
   endtask

   // Applies one request to the shadow set and returns the response it must give.
   function automatic set_answer_type apply_request(input logic [2:0] op,
                                                    input logic [ELEM_W-1:0] elem,
                                                    input logic [ELEM_W-1:0] idx,
                                                    input logic [RND_W-1:0] rnd);
      set_answer_type    ans;
      logic [ELEM_W-1:0] freed;
      logic [ELEM_W-1:0] last;
      ans.serial = accepted;
      ans.op     = op;
      ans.hit    = 1'b0;
      ans.value  = '0;
      ans.status = rass_pkg::STATUS_OK;
      case (op)
         rass_pkg::FUNC_ADD: begin
            if (!in_set[elem] && members < SET_SIZE) begin
               in_set[elem]                   = 1'b1;
               dense_slots[members[ELEM_W-1:0]] = elem;
               slot_of[elem]                  = members[ELEM_W-1:0];
               members                        = members + 1'b1;
               ans.hit                        = 1'b1;
            end
         end
         rass_pkg::FUNC_REMOVE: begin
            // last member moves into the freed slot
            if (in_set[elem] && members != 0) begin
               in_set[elem]       = 1'b0;
               members            = members - 1'b1;
               freed              = slot_of[elem];
               last               = dense_slots[members[ELEM_W-1:0]];
               dense_slots[freed] = last;
               slot_of[last]      = freed;
               ans.hit            = 1'b1;
            end
         end
         rass_pkg::FUNC_CONTAINS: ans.hit = in_set[elem];
         rass_pkg::FUNC_GET: begin
            if (idx < members) ans.value = dense_slots[idx];
            else               ans.status = rass_pkg::STATUS_RANGE;
         end
         rass_pkg::FUNC_PICK: begin
            if (members == 0) ans.status = rass_pkg::STATUS_EMPTY;
            else              ans.value  = dense_slots[rnd % members];
         end
         rass_pkg::FUNC_CLEAR: begin
            in_set  = '0;
            members = '0;
         end
         default: ;
      endcase
      ans.count = members;
      return ans;
   endfunction

   always @(posedge clock) begin
      set_answer_type want;
      if (reset) begin
         in_set  = '0;
         members = '0;
         awaited.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing outstanding (count %0d)",
                                         rsp_member_count));
            end else begin
               want = awaited.pop_front();
               checks++;
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("beat %0d func %0d: hit %b, want %b",
                                            want.serial, want.op, rsp_hit, want.hit));
               if (rsp_value_out !== want.value)
                  report_mismatch($sformatf("beat %0d func %0d: value_out %0d, want %0d",
                                            want.serial, want.op, rsp_value_out, want.value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("beat %0d func %0d: status %0d, want %0d",
                                            want.serial, want.op, rsp_status, want.status));
               if (rsp_member_count !== want.count)
                  report_mismatch($sformatf("beat %0d func %0d: member_count %0d, want %0d",
                                            want.serial, want.op, rsp_member_count,
                                            want.count));
            end
         end
         if (req_valid && !req_stall) begin
            awaited.push_back(apply_request(req_func, req_element, req_slot_index,
                                            req_random_value));
            accepted++;
         end
      end
      fail_total <= errors;
      pending    <= awaited.size();
      answered   <= checks;
   end

endmodule

[tb/sv/random_access_sparse_set_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_access_sparse_set_test
// Drives request beats into the sparse set and gives the verdict; the checker
// beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------

module random_access_sparse_set_test;

   localparam int ELEM_W       = rass_pkg::ELEM_W;
   localparam int RND_W        = rass_pkg::RND_W;
   localparam int COUNT_PORT_W = rass_pkg::COUNT_PORT_W;
   localparam int SET_SIZE     = rass_pkg::ELEM_SPAN;
   localparam int IDLE_PCT     = 14;      // chance per cycle that a side idles
   localparam int RANDOM_ITEMS = 880;
   localparam int SEGMENT_LEN  = 50;      // random beats per element pool
   localparam int HOLD_CYCLES  = 300;     // long response hold-off
   localparam int DRAIN_CYCLES = 64;      // beyond the slowest op (random pick)
   localparam int WATCHDOG_NS  = 1_000_000;

   // codes outside the defined operations; the block must leave the set alone
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_func         = '0;
   logic [ELEM_W-1:0]        req_element      = '0;
   logic [ELEM_W-1:0]        req_slot_index   = '0;
   logic [RND_W-1:0]         req_random_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic                     rsp_hit;
   logic [ELEM_W-1:0]        rsp_value_out;
   logic [1:0]               rsp_status;
   logic [COUNT_PORT_W-1:0]  rsp_member_count;

   int unsigned fail_total;
   int unsigned pending;
   int unsigned answered;

   // no_idle and hold_request are shared between the request and response processes
   bit          no_idle      = 1'b0;   // both sides run flat out while set
   bit          hold_request = 1'b0;   // asks the response side for the long hold-off
   int unsigned sent_by_op [8];

   // current random element pool: base plus a span that changes per segment
   int unsigned pool_base;
   int unsigned pool_span;
   int unsigned clear_pct;

   random_access_sparse_set dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_element      (req_element),
      .req_slot_index   (req_slot_index),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_value_out    (rsp_value_out),
      .rsp_status       (rsp_status),
      .rsp_member_count (rsp_member_count)
   );

   random_access_sparse_set_check checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_element      (req_element),
      .req_slot_index   (req_slot_index),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_value_out    (rsp_value_out),
      .rsp_status       (rsp_status),
      .rsp_member_count (rsp_member_count),
      .fail_total       (fail_total),
      .pending          (pending),
      .answered         (answered)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop: covers the reset sweep, epoch-wrap sweeps, a run of random
   // picks and every stall, several times over.
   initial begin
      #(WATCHDOG_NS);
      $display("Timeout: request or response channel stopped moving");
      $display("DONE: errors detected");
      $finish;
   end

   // Offers one request beat and returns once the block has taken it.
   // Called right after a rising edge; valid stays high across back-to-back
   // beats and is only lowered for an idle cycle.
   task automatic offer_request(input logic [2:0]        op,
                                input logic [ELEM_W-1:0] elem,
                                input logic [ELEM_W-1:0] idx,
                                input logic [RND_W-1:0]  rnd);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= op;
      req_element      <= elem;
      req_slot_index   <= idx;
      req_random_value <= rnd;
      @(posedge clock);
      // stall as seen at this edge decides whether the beat moved
      while (req_stall) @(posedge clock);
      sent_by_op[op]++;
   endtask

   // Mostly from the current pool so adds, removes and lookups hit each other;
   // now and then anywhere in the 10-bit range.
   function automatic logic [ELEM_W-1:0] pool_element();
      if ($urandom_range(19) == 0) return ELEM_W'($urandom);
      return ELEM_W'(pool_base + $urandom_range(pool_span));
   endfunction

   // Slots just past the pool size give a mix of valid and out-of-range gets.
   function automatic logic [ELEM_W-1:0] pool_slot();
      if ($urandom_range(19) == 0) return ELEM_W'($urandom);
      return ELEM_W'($urandom_range(pool_span + 2));
   endfunction

   task automatic random_request();
      int unsigned roll;
      logic [2:0]  op;
      roll = $urandom_range(99);
      if (roll < clear_pct)
         op = rass_pkg::FUNC_CLEAR;
      else if (roll < clear_pct + 3)
         op = $urandom_range(1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      else begin
         roll = $urandom_range(99);
         if      (roll < 38) op = rass_pkg::FUNC_ADD;
         else if (roll < 62) op = rass_pkg::FUNC_REMOVE;
         else if (roll < 76) op = rass_pkg::FUNC_CONTAINS;
         else if (roll < 88) op = rass_pkg::FUNC_GET;
         else                op = rass_pkg::FUNC_PICK;
      end
      offer_request(op, pool_element(), pool_slot(), RND_W'($urandom));
   endtask

   // Response side: random stalls, one long hold-off on request, and no
   // stalls at all while no_idle is set.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall   <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Request side and verdict.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty set, extremes, duplicates, swaps on remove ---
      offer_request(rass_pkg::FUNC_PICK, '0, '0, '1);            // pick on empty set
      offer_request(rass_pkg::FUNC_GET, '0, '0, '0);             // get on empty set
      offer_request(rass_pkg::FUNC_REMOVE, 10'd5, '0, '0);       // remove of a non-member
      offer_request(rass_pkg::FUNC_CONTAINS, '0, '0, '0);
      offer_request(rass_pkg::FUNC_ADD, '0, '0, '0);
      offer_request(rass_pkg::FUNC_ADD, '1, '0, '0);
      offer_request(rass_pkg::FUNC_ADD, '0, '0, '0);             // add of a member
      offer_request(rass_pkg::FUNC_CONTAINS, '1, '0, '0);
      offer_request(rass_pkg::FUNC_GET, '0, 10'd0, '0);
      offer_request(rass_pkg::FUNC_GET, '0, 10'd1, '0);
      offer_request(rass_pkg::FUNC_GET, '0, 10'd2, '0);          // index equal to count
      offer_request(rass_pkg::FUNC_GET, '0, '1, '0);
      offer_request(rass_pkg::FUNC_PICK, '0, '0, '0);
      offer_request(rass_pkg::FUNC_PICK, '0, '0, '1);
      offer_request(rass_pkg::FUNC_ADD, 10'd512, '0, '0);
      offer_request(rass_pkg::FUNC_REMOVE, '0, '0, '0);          // head slot: last member moves in
      offer_request(rass_pkg::FUNC_REMOVE, 10'd512, '0, '0);     // head slot again: last member moves in
      offer_request(rass_pkg::FUNC_GET, '0, 10'd0, '0);
      offer_request(FUNC_SPARE_LO, '1, '1, '1);
      offer_request(FUNC_SPARE_HI, '1, '1, '1);
      offer_request(rass_pkg::FUNC_CLEAR, '1, '1, '1);
      offer_request(rass_pkg::FUNC_CONTAINS, '1, '0, '0);        // gone after clear
      offer_request(rass_pkg::FUNC_GET, '0, 10'd0, '0);

      // --- random: pools of varied size, some segments heavy on clears so
      //     the membership epoch wraps and forces a sweep ---
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            case ($urandom_range(3))
               0:       pool_span = 7;
               1:       pool_span = 31;
               2:       pool_span = 127;
               default: pool_span = SET_SIZE - 1;
            endcase
            pool_base = $urandom_range(SET_SIZE - 1);
            clear_pct = ($urandom_range(3) == 0) ? 25 : 4;
         end
         no_idle = (n >= 200 && n < 350);
         if (n == 600) hold_request = 1'b1;   // sender keeps offering meanwhile
         random_request();
      end
      req_valid <= 1'b0;

      // let the last beat reach the checker's count, then drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request beats: %0d add, %0d remove, %0d contains, %0d get, %0d pick,",
               sent_by_op.sum(), sent_by_op[rass_pkg::FUNC_ADD],
               sent_by_op[rass_pkg::FUNC_REMOVE], sent_by_op[rass_pkg::FUNC_CONTAINS],
               sent_by_op[rass_pkg::FUNC_GET], sent_by_op[rass_pkg::FUNC_PICK]);
      $display("%0d clear, %0d spare codes; %0d responses checked, %0d-cycle hold-off",
               sent_by_op[rass_pkg::FUNC_CLEAR],
               sent_by_op[FUNC_SPARE_LO] + sent_by_op[FUNC_SPARE_HI],
               answered, HOLD_CYCLES);
      if (fail_total == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
